FILE: hdl/apbo_pkg.sv
package apbo_pkg;

   localparam int KEY_W   = 8;
   localparam int OWNER_W = 8;
   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   // right = left + width and bottom = top + height stay exact in 18 bits
   localparam int EDGE_W  = 18;

   localparam int OP_W     = 2;
   localparam int KIND_W   = 2;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = KIND_W;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PAIR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Field order matches req_tdata from the top bit down, so a box
   // unpacks straight from the low bits of the word.
   typedef struct packed {
      logic [SIZE_W-1:0]  height;
      logic [SIZE_W-1:0]  width;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
      logic [OWNER_W-1:0] owner;
      logic [KEY_W-1:0]   key;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Strict interior overlap on both axes; touching edges miss.
   function automatic logic boxes_overlap(entry_type a, entry_type b);
      logic signed [EDGE_W-1:0] a_l;
      logic signed [EDGE_W-1:0] a_r;
      logic signed [EDGE_W-1:0] a_t;
      logic signed [EDGE_W-1:0] a_b;
      logic signed [EDGE_W-1:0] b_l;
      logic signed [EDGE_W-1:0] b_r;
      logic signed [EDGE_W-1:0] b_t;
      logic signed [EDGE_W-1:0] b_b;
      begin
         a_l = {{(EDGE_W-COORD_W){a.left[COORD_W-1]}}, a.left};
         a_t = {{(EDGE_W-COORD_W){a.top[COORD_W-1]}}, a.top};
         b_l = {{(EDGE_W-COORD_W){b.left[COORD_W-1]}}, b.left};
         b_t = {{(EDGE_W-COORD_W){b.top[COORD_W-1]}}, b.top};
         a_r = a_l + {{(EDGE_W-SIZE_W){1'b0}}, a.width};
         a_b = a_t + {{(EDGE_W-SIZE_W){1'b0}}, a.height};
         b_r = b_l + {{(EDGE_W-SIZE_W){1'b0}}, b.width};
         b_b = b_t + {{(EDGE_W-SIZE_W){1'b0}}, b.height};
         boxes_overlap = (a_l < b_r) && (b_l < a_r) && (a_t < b_b) && (b_t < a_b);
      end
   endfunction

endpackage

FILE: hdl/all_pairs_box_overlap_scan.sv
// Channel  Dir  tuser      tdata (low bit up)                            tlast
// req      in   op[1:0]    key, owner, left, top, width, height, 2 pad  -
// rsp      out  kind[1:0]  status, first_owner, second_owner, 7 pad      last result
//
// Add appends the box in the idle state, then posts its acknowledge word.
// Remove walks the table, reading then checking each stored entry through
// the single read/compact path, then the acknowledge. Scan runs one shared
// overlap unit over every ordered pair: a table read, then a test, per pair.
// Reset clears the box count, the sequencer and the output valid; box
// contents are kept in a memory that is not cleared.
// A held rsp word stalls only the step that needs the output register;
// req_tready is high whenever the sequencer is idle.
module all_pairs_box_overlap_scan #(
   parameter int MAX_BOXES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // key[7:0], owner[15:8], left_x[31:16], top_y[47:32],
   // box_width[62:48], box_height[77:63], zero[79:78]
   input  logic [apbo_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op[1:0]
   input  logic [apbo_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[0], first_owner[8:1], second_owner[16:9], zero[23:17]
   output logic [apbo_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // kind[1:0]
   output logic [apbo_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast
);
   import apbo_pkg::*;

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_REM_RD,
      ST_REM_CHK,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   w_ff, w_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [OWNER_W-1:0] rsp_first_ff, rsp_first_in;
   logic [OWNER_W-1:0] rsp_second_ff, rsp_second_in;
   logic               rsp_last_ff, rsp_last_in;

   // box table: one write port, two registered read ports at i and j
   entry_type          entry_mem_ff [MAX_BOXES];
   entry_type          rd_a_ff;
   entry_type          rd_b_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;

   entry_type          req_entry;
   logic               out_free;
   logic               pair_hit;
   logic               i_last;
   logic               j_last;

   assign req_entry = entry_type'(req_tdata[ENTRY_W-1:0]);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pair_hit  = (rd_a_ff.key != rd_b_ff.key) && boxes_overlap(rd_a_ff, rd_b_ff);
   assign i_last    = (CNT_W'(i_ff) + CNT_W'(1)) == count_ff;
   assign j_last    = (CNT_W'(j_ff) + CNT_W'(1)) == count_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 1 - 2*OWNER_W){1'b0}},
                        rsp_second_ff, rsp_first_ff, rsp_status_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= entry_mem_ff[i_ff];
      rd_b_ff <= entry_mem_ff[j_ff];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      w_in          = w_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[IDX_W-1:0];
      mem_wdata     = req_entry;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_tuser)
                  OP_ADD: begin
                     state_in = ST_ACK;
                     if (count_ff == CNT_W'(MAX_BOXES)) begin
                        status_in = STATUS_FULL;   // drop the box
                     end else begin
                        status_in = STATUS_OK;
                        mem_we    = 1'b1;          // append at the end
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     key_in    = req_entry.key;
                     status_in = STATUS_OK;
                     i_in      = '0;
                     w_in      = '0;
                     state_in  = (count_ff == '0) ? ST_ACK : ST_REM_RD;
                  end
                  OP_SCAN: begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = (count_ff == '0) ? ST_DONE : ST_SCAN_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;           // unused op: drop the word
                  end
               endcase
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ACK;
               rsp_status_in = status_ff;
               rsp_first_in  = '0;
               rsp_second_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_DONE;
               rsp_status_in = STATUS_OK;
               rsp_first_in  = '0;
               rsp_second_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_REM_RD: begin
            state_in = ST_REM_CHK;
         end

         ST_REM_CHK: begin
            // compact in place: keep survivors at the write pointer
            if (rd_a_ff.key != key_ff) begin
               mem_we    = 1'b1;
               mem_waddr = w_ff[IDX_W-1:0];
               mem_wdata = rd_a_ff;
               w_in      = w_ff + CNT_W'(1);
            end
            if (i_last) begin
               count_in = w_in;
               state_in = ST_ACK;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_REM_RD;
            end
         end

         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end

         ST_SCAN_CMP: begin
            // hold the pair until the output register frees up
            if (!pair_hit || out_free) begin
               if (pair_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_PAIR;
                  rsp_status_in = STATUS_OK;
                  rsp_first_in  = rd_a_ff.owner;
                  rsp_second_in = rd_b_ff.owner;
                  rsp_last_in   = 1'b0;
               end
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = ST_DONE;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = ST_SCAN_RD;
                  end
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_SCAN_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      w_ff          <= w_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
